>>> hdl/mcbe_pkg.sv
// Package for the mapping cache with batch eviction.
// Holds operation and result-kind codes and the command and result structs.
// No dependencies.
package mcbe_pkg;

   typedef enum logic [1:0] {
      OP_TRANSLATE = 2'd0,
      OP_MAP       = 2'd1,
      OP_FILL      = 2'd2,
      OP_SET_DIR   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_TRANSLATED = 3'd0,
      KIND_FETCH      = 3'd1,
      KIND_WRITEBACK  = 3'd2,
      KIND_NOT_MAPPED = 3'd3,
      KIND_RANGE      = 3'd4,
      KIND_DONE       = 3'd5,
      KIND_PROTOCOL   = 3'd6
   } kind_type;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam int TPAGE_SHIFT       = 9;
   localparam int ENTRIES_PER_TPAGE = 1 << TPAGE_SHIFT;

   typedef struct packed {
      op_type      op;
      logic [15:0] lpa;
      logic [31:0] ppa;
      logic [6:0]  dir_slot;
   } cmd_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] lpa;
      logic [31:0] ppa;
      logic [31:0] tpage_addr;
      logic [6:0]  tpage_index;
      logic [10:0] byte_offset;
      logic        last;
   } rsp_type;

endpackage

>>> hdl/mcbe_cmd_fifo.sv
// Short command queue between the request front end and the cache engine.
// Depends on mcbe_pkg for the command struct.
module mcbe_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mcbe_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output mcbe_pkg::cmd_type out_cmd
);

   mcbe_pkg::cmd_type buf_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = buf_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

>>> hdl/mcbe_engine.sv
// Cache engine: lookup, oldest-first eviction, directory and result output.
// Depends on mcbe_pkg; fed by mcbe_cmd_fifo.
module mcbe_engine #(
   parameter int CACHE_ENTRIES     = 32,
   parameter int DIRECTORY_ENTRIES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  mcbe_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcbe_pkg::rsp_type rsp
);

   localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int NW = $clog2(CACHE_ENTRIES + 1);
   localparam int DW = (DIRECTORY_ENTRIES > 1) ? $clog2(DIRECTORY_ENTRIES) : 1;
   localparam int TS = mcbe_pkg::TPAGE_SHIFT;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_DIR    = 8'b00000010,
      ST_DECIDE = 8'b00000100,
      ST_EVSCAN = 8'b00001000,
      ST_EVICT  = 8'b00010000,
      ST_FINAL  = 8'b00100000,
      ST_OUT    = 8'b01000000,
      ST_CLEAR  = 8'b10000000
   } state_type;

   state_type state_ff;
   mcbe_pkg::cmd_type cmd_ff;

   logic [15:0] e_lpa_ff [CACHE_ENTRIES];
   logic [31:0] e_ppa_ff [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] e_dirty_ff;
   logic [CW-1:0] e_age_ff [CACHE_ENTRIES];
   logic [NW-1:0] count_ff;
   logic fetch_pending_ff;
   logic [15:0] pending_lpa_ff;

   logic [31:0] dir_mem [DIRECTORY_ENTRIES];
   logic [31:0] dir_q_ff;
   logic        dir_ok_ff;
   logic [31:0] dir_val;
   logic [DW-1:0] clr_ff;

   logic [CACHE_ENTRIES-1:0] hit_vec, rank_vec;
   logic        hit_ff;
   logic [CW-1:0] hit_slot_ff;
   logic [CW-1:0] rank_ff;
   logic [6:0]  ev_idx_ff;
   logic [31:0] ev_dir_ff;
   logic        ev_flag_ff;
   logic        rank_found;
   logic [CW-1:0] rank_slot;

   mcbe_pkg::rsp_type out_ff;
   logic out_valid_ff;
   logic [CW-1:0] last_slot;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;
   assign last_slot = CW'(count_ff - NW'(1));
   assign dir_val   = dir_ok_ff ? dir_q_ff : mcbe_pkg::ALL_ONES;

   function automatic logic [6:0] tidx(input logic [15:0] lpa);
      return 7'(lpa >> TS);
   endfunction

   function automatic logic [10:0] boff(input logic [15:0] lpa);
      logic [15:0] rem;
      rem = lpa & 16'(mcbe_pkg::ENTRIES_PER_TPAGE - 1);
      return 11'({rem, 2'b00});
   endfunction

   function automatic logic in_dir(input logic [15:0] lpa);
      return (32'(lpa) >> TS) < 32'(DIRECTORY_ENTRIES);
   endfunction

   always_comb begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         hit_vec[i]  = (NW'(i) < count_ff) && (e_lpa_ff[i] == cmd_ff.lpa);
         rank_vec[i] = (NW'(i) < count_ff) && (e_age_ff[i] == rank_ff);
      end
   end

   always_comb begin
      rank_found = 1'b0;
      rank_slot  = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (rank_vec[i]) begin
            rank_found = 1'b1;
            rank_slot  = CW'(i);
         end
      end
   end

   function automatic mcbe_pkg::rsp_type mk(input mcbe_pkg::kind_type k,
      input logic [15:0] lpa, input logic [31:0] ppa, input logic [31:0] ta,
      input logic l);
      mcbe_pkg::rsp_type r;
      r.kind = k; r.lpa = lpa; r.ppa = ppa; r.tpage_addr = ta;
      r.tpage_index = tidx(lpa); r.byte_offset = boff(lpa); r.last = l;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= '0;
         count_ff         <= '0;
         e_dirty_ff       <= '0;
         fetch_pending_ff <= 1'b0;
         pending_lpa_ff   <= '0;
         out_valid_ff     <= 1'b0;
         for (int i = 0; i < CACHE_ENTRIES; i++) e_age_ff[i] <= '0;
      end else begin
         if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               dir_mem[clr_ff] <= mcbe_pkg::ALL_ONES;
               clr_ff <= clr_ff + DW'(1);
               if (clr_ff == DW'(DIRECTORY_ENTRIES - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd;
                  state_ff <= ST_DIR;
               end
            end
            ST_DIR: begin
               hit_ff <= |hit_vec;
               for (int i = 0; i < CACHE_ENTRIES; i++)
                  if (hit_vec[i]) hit_slot_ff <= CW'(i);
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (!out_valid_ff) begin
                  state_ff <= ST_IDLE;
                  case (cmd_ff.op)
                     mcbe_pkg::OP_SET_DIR: begin
                        out_valid_ff <= 1'b1;
                        out_ff.lpa <= '0; out_ff.ppa <= '0; out_ff.byte_offset <= '0;
                        out_ff.tpage_index <= cmd_ff.dir_slot; out_ff.last <= 1'b1;
                        if (32'(cmd_ff.dir_slot) < 32'(DIRECTORY_ENTRIES)) begin
                           dir_mem[DW'(cmd_ff.dir_slot)] <= cmd_ff.ppa;
                           out_ff.kind <= mcbe_pkg::KIND_DONE;
                           out_ff.tpage_addr <= cmd_ff.ppa;
                        end else begin
                           out_ff.kind <= mcbe_pkg::KIND_RANGE;
                           out_ff.tpage_addr <= mcbe_pkg::ALL_ONES;
                        end
                     end
                     mcbe_pkg::OP_TRANSLATE: begin
                        out_valid_ff <= 1'b1;
                        if (hit_ff)
                           out_ff <= mk(mcbe_pkg::KIND_TRANSLATED, cmd_ff.lpa,
                                        e_ppa_ff[hit_slot_ff], dir_val, 1'b1);
                        else if (!dir_ok_ff)
                           out_ff <= mk(mcbe_pkg::KIND_RANGE, cmd_ff.lpa, '0,
                                        dir_val, 1'b1);
                        else if (dir_q_ff == mcbe_pkg::ALL_ONES)
                           out_ff <= mk(mcbe_pkg::KIND_NOT_MAPPED, cmd_ff.lpa,
                                        mcbe_pkg::ALL_ONES, dir_val, 1'b1);
                        else begin
                           fetch_pending_ff <= 1'b1;
                           pending_lpa_ff   <= cmd_ff.lpa;
                           out_ff <= mk(mcbe_pkg::KIND_FETCH, cmd_ff.lpa, '0,
                                        dir_val, 1'b1);
                        end
                     end
                     mcbe_pkg::OP_MAP: begin
                        if (!dir_ok_ff) begin
                           out_valid_ff <= 1'b1;
                           out_ff <= mk(mcbe_pkg::KIND_RANGE, cmd_ff.lpa, '0,
                                        dir_val, 1'b1);
                        end else if (hit_ff) begin
                           if (e_ppa_ff[hit_slot_ff] != cmd_ff.ppa) begin
                              e_ppa_ff[hit_slot_ff]   <= cmd_ff.ppa;
                              e_dirty_ff[hit_slot_ff] <= 1'b1;
                           end
                           for (int i = 0; i < CACHE_ENTRIES; i++)
                              if (NW'(i) < count_ff &&
                                  e_age_ff[i] > e_age_ff[hit_slot_ff])
                                 e_age_ff[i] <= e_age_ff[i] - CW'(1);
                           e_age_ff[hit_slot_ff] <= last_slot;
                           out_valid_ff <= 1'b1;
                           out_ff <= mk(mcbe_pkg::KIND_DONE, cmd_ff.lpa,
                                        cmd_ff.ppa, dir_val, 1'b1);
                        end else begin
                           rank_ff    <= '0;
                           ev_flag_ff <= 1'b0;
                           state_ff   <= (count_ff >= NW'(CACHE_ENTRIES)) ?
                                         ST_EVSCAN : ST_FINAL;
                        end
                     end
                     default: begin
                        if (!fetch_pending_ff || pending_lpa_ff != cmd_ff.lpa) begin
                           out_valid_ff <= 1'b1;
                           out_ff <= mk(mcbe_pkg::KIND_PROTOCOL, cmd_ff.lpa, '0,
                                        dir_val, 1'b1);
                        end else begin
                           fetch_pending_ff <= 1'b0;
                           if (hit_ff) begin
                              out_valid_ff <= 1'b1;
                              out_ff <= mk(mcbe_pkg::KIND_TRANSLATED, cmd_ff.lpa,
                                           e_ppa_ff[hit_slot_ff], dir_val, 1'b1);
                           end else if (cmd_ff.ppa == mcbe_pkg::ALL_ONES) begin
                              out_valid_ff <= 1'b1;
                              out_ff <= mk(mcbe_pkg::KIND_NOT_MAPPED, cmd_ff.lpa,
                                           mcbe_pkg::ALL_ONES, dir_val, 1'b1);
                           end else begin
                              rank_ff    <= '0;
                              ev_flag_ff <= 1'b0;
                              state_ff   <= (count_ff >= NW'(CACHE_ENTRIES)) ?
                                            ST_EVSCAN : ST_FINAL;
                           end
                        end
                     end
                  endcase
               end
            end
            ST_EVSCAN: begin
               // Oldest entry: clean leaves alone, dirty starts a page sweep.
               if (!e_dirty_ff[rank_slot]) begin
                  for (int i = 0; i < CACHE_ENTRIES; i++)
                     if (e_age_ff[i] > e_age_ff[rank_slot])
                        e_age_ff[i] <= e_age_ff[i] - CW'(1);
                  if (rank_slot != last_slot) begin
                     e_lpa_ff[rank_slot]   <= e_lpa_ff[last_slot];
                     e_ppa_ff[rank_slot]   <= e_ppa_ff[last_slot];
                     e_dirty_ff[rank_slot] <= e_dirty_ff[last_slot];
                     e_age_ff[rank_slot]   <= e_age_ff[last_slot] -
                        ((e_age_ff[last_slot] > e_age_ff[rank_slot]) ? CW'(1) : CW'(0));
                  end
                  count_ff <= count_ff - NW'(1);
                  state_ff <= ST_FINAL;
               end else begin
                  ev_idx_ff <= tidx(e_lpa_ff[rank_slot]);
                  ev_dir_ff <= in_dir(e_lpa_ff[rank_slot]) ?
                               dir_mem[DW'(tidx(e_lpa_ff[rank_slot]))] :
                               mcbe_pkg::ALL_ONES;
                  state_ff  <= ST_EVICT;
               end
            end
            ST_EVICT: begin
               if (!rank_found || NW'(rank_ff) >= count_ff) begin
                  state_ff <= ST_FINAL;
               end else if (tidx(e_lpa_ff[rank_slot]) != ev_idx_ff) begin
                  rank_ff <= rank_ff + CW'(1);
               end else if (!(e_dirty_ff[rank_slot] && out_valid_ff)) begin
                  if (e_dirty_ff[rank_slot]) begin
                     out_valid_ff <= 1'b1;
                     out_ff <= mk(mcbe_pkg::KIND_WRITEBACK, e_lpa_ff[rank_slot],
                        e_ppa_ff[rank_slot], ev_dir_ff, 1'b0);
                  end
                  for (int i = 0; i < CACHE_ENTRIES; i++)
                     if (e_age_ff[i] > e_age_ff[rank_slot])
                        e_age_ff[i] <= e_age_ff[i] - CW'(1);
                  if (rank_slot != last_slot) begin
                     e_lpa_ff[rank_slot]   <= e_lpa_ff[last_slot];
                     e_ppa_ff[rank_slot]   <= e_ppa_ff[last_slot];
                     e_dirty_ff[rank_slot] <= e_dirty_ff[last_slot];
                     e_age_ff[rank_slot]   <= e_age_ff[last_slot] -
                        ((e_age_ff[last_slot] > e_age_ff[rank_slot]) ? CW'(1) : CW'(0));
                  end
                  count_ff <= count_ff - NW'(1);
               end
            end
            ST_FINAL: begin
               if (!out_valid_ff) begin
                  if (count_ff < NW'(CACHE_ENTRIES)) begin
                     e_lpa_ff[last_slot + CW'(1)]   <= cmd_ff.lpa;
                     e_ppa_ff[last_slot + CW'(1)]   <= cmd_ff.ppa;
                     e_dirty_ff[last_slot + CW'(1)] <= (cmd_ff.op == mcbe_pkg::OP_MAP);
                     e_age_ff[last_slot + CW'(1)]   <= CW'(count_ff);
                     count_ff <= count_ff + NW'(1);
                  end
                  out_valid_ff <= 1'b1;
                  out_ff <= mk((cmd_ff.op == mcbe_pkg::OP_MAP) ? mcbe_pkg::KIND_DONE :
                               mcbe_pkg::KIND_TRANSLATED, cmd_ff.lpa, cmd_ff.ppa,
                               dir_val, 1'b1);
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd_valid) begin
         dir_ok_ff <= in_dir(cmd.lpa);
      end
      if (state_ff == ST_DIR) begin
         dir_q_ff <= dir_mem[DW'(tidx(cmd_ff.lpa))];
      end
   end

endmodule

>>> hdl/mapping_cache_batch_evict.sv
// Top level of the mapping cache with batch eviction.
// Instantiates mcbe_cmd_fifo (front queue) and mcbe_engine (back end); uses mcbe_pkg.
//
// Channel | Direction | Contents
// req     | in        | tuser: op; tdata: lpa, ppa, dir_slot
// rsp     | out       | tuser: kind; tdata: out_lpa, out_ppa, tpage_addr,
//         |           | tpage_index, byte_offset; tlast: last
//
// A word passes the engine states take, lookup and answer; a word that inserts
// also passes the insert state. A full cache first checks the oldest entry and,
// when it is dirty, sweeps the ranks, removing the entries of its page and
// writing back the dirty ones. Reset is synchronous and clears the cache; the
// directory is then set to free one entry at a time before the first word.
// Either side may stall; a waiting result holds the engine; the queue holds two words.
module mapping_cache_batch_evict #(
   parameter int CACHE_ENTRIES     = 32,
   parameter int DIRECTORY_ENTRIES = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,  // lpa, ppa, dir_slot, zero fill
   input  logic [1:0]   req_tuser,  // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // out_lpa, out_ppa, tpage_addr,
                                    // tpage_index, byte_offset, zero fill
   output logic [2:0]   rsp_tuser,  // kind
   output logic         rsp_tlast
);

   mcbe_pkg::cmd_type in_cmd, q_cmd;
   mcbe_pkg::rsp_type r;
   logic q_valid, q_ready;

   assign in_cmd.op       = mcbe_pkg::op_type'(req_tuser);
   assign in_cmd.lpa      = req_tdata[15:0];
   assign in_cmd.ppa      = req_tdata[47:16];
   assign in_cmd.dir_slot = req_tdata[54:48];

   mcbe_cmd_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   mcbe_engine #(
      .CACHE_ENTRIES(CACHE_ENTRIES),
      .DIRECTORY_ENTRIES(DIRECTORY_ENTRIES)
   ) u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(r)
   );

   assign rsp_tdata = {6'd0, r.byte_offset, r.tpage_index, r.tpage_addr,
                       r.ppa, r.lpa};
   assign rsp_tuser = 3'(r.kind);
   assign rsp_tlast = r.last;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed under stall");
   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= 3'(mcbe_pkg::KIND_PROTOCOL))
      else $error("bad result kind");
   a_wb_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == 3'(mcbe_pkg::KIND_WRITEBACK) |-> !rsp_tlast)
      else $error("writeback marked last");

endmodule

>>> verif/tb_mapping_cache_batch_evict.sv
// Self-checking testbench for mapping_cache_batch_evict.
// Drives translate, map, fill and directory words and checks every result word
// against a scoreboard that predicts the cache; depends on mcbe_pkg and the RTL.
`timescale 1ns / 100ps

module tb_mapping_cache_batch_evict;

   class mapping_scoreboard;
      logic [15:0] slot_lpa [32];
      logic [31:0] slot_ppa [32];
      bit          slot_dirty [32];
      int          slot_rank [32];
      int          filled;
      logic [31:0] dir_loc [128];
      bit          fetch_open;
      logic [15:0] fetch_lpa;
      mcbe_pkg::rsp_type awaited [$];
      int          errors;

      function void clear();
         filled = 0;
         fetch_open = 0;
         fetch_lpa = '0;
         foreach (dir_loc[i]) dir_loc[i] = mcbe_pkg::ALL_ONES;
         foreach (slot_dirty[i]) begin
            slot_dirty[i] = 0;
            slot_rank[i] = 0;
         end
         errors = 0;
      endfunction

      function void push(mcbe_pkg::kind_type k, logic [15:0] lpa, logic [31:0] ppa);
         mcbe_pkg::rsp_type r;
         r.kind = k;
         r.lpa = lpa;
         r.ppa = ppa;
         r.tpage_addr = dir_loc[lpa[15:9]];
         r.tpage_index = lpa[15:9];
         r.byte_offset = {lpa[8:0], 2'b00};
         r.last = 1'b0;
         awaited.push_back(r);
      endfunction

      function int find_lpa(logic [15:0] lpa);
         for (int s = 0; s < filled; s++)
            if (slot_lpa[s] == lpa) return s;
         return -1;
      endfunction

      function int find_rank(int rank);
         for (int s = 0; s < filled; s++)
            if (slot_rank[s] == rank) return s;
         return -1;
      endfunction

      function void drop(int s);
         int r;
         r = slot_rank[s];
         for (int i = 0; i < filled; i++)
            if (slot_rank[i] > r) slot_rank[i]--;
         if (s != filled - 1) begin
            slot_lpa[s] = slot_lpa[filled-1];
            slot_ppa[s] = slot_ppa[filled-1];
            slot_dirty[s] = slot_dirty[filled-1];
            slot_rank[s] = slot_rank[filled-1];
         end
         filled--;
      endfunction

      function void evict_oldest();
         int v;
         int r;
         int s;
         logic [6:0] page;
         v = find_rank(0);
         if (v < 0) return;
         if (!slot_dirty[v]) begin
            drop(v);
            return;
         end
         page = slot_lpa[v][15:9];
         r = 0;
         while (r < filled) begin
            s = find_rank(r);
            if (s < 0) break;
            if (slot_lpa[s][15:9] == page) begin
               if (slot_dirty[s])
                  push(mcbe_pkg::KIND_WRITEBACK, slot_lpa[s], slot_ppa[s]);
               drop(s);
            end else begin
               r++;
            end
         end
      endfunction

      function void add_entry(logic [15:0] lpa, logic [31:0] ppa, bit dirty);
         if (filled >= 32) evict_oldest();
         if (filled >= 32) return;
         slot_lpa[filled] = lpa;
         slot_ppa[filled] = ppa;
         slot_dirty[filled] = dirty;
         slot_rank[filled] = filled;
         filled++;
      endfunction

      function void note_word(mcbe_pkg::cmd_type c);
         int s;
         int r;
         mcbe_pkg::rsp_type t;
         case (c.op)
            mcbe_pkg::OP_SET_DIR: begin
               dir_loc[c.dir_slot] = c.ppa;
               t = '0;
               t.kind = mcbe_pkg::KIND_DONE;
               t.tpage_addr = c.ppa;
               t.tpage_index = c.dir_slot;
               awaited.push_back(t);
            end
            mcbe_pkg::OP_TRANSLATE: begin
               s = find_lpa(c.lpa);
               if (s >= 0) push(mcbe_pkg::KIND_TRANSLATED, c.lpa, slot_ppa[s]);
               else if (dir_loc[c.lpa[15:9]] == mcbe_pkg::ALL_ONES)
                  push(mcbe_pkg::KIND_NOT_MAPPED, c.lpa, mcbe_pkg::ALL_ONES);
               else begin
                  fetch_open = 1;
                  fetch_lpa = c.lpa;
                  push(mcbe_pkg::KIND_FETCH, c.lpa, '0);
               end
            end
            mcbe_pkg::OP_MAP: begin
               s = find_lpa(c.lpa);
               if (s >= 0) begin
                  if (slot_ppa[s] != c.ppa) begin
                     slot_ppa[s] = c.ppa;
                     slot_dirty[s] = 1;
                  end
                  r = slot_rank[s];
                  for (int i = 0; i < filled; i++)
                     if (slot_rank[i] > r) slot_rank[i]--;
                  slot_rank[s] = filled - 1;
               end else begin
                  add_entry(c.lpa, c.ppa, 1);
               end
               push(mcbe_pkg::KIND_DONE, c.lpa, c.ppa);
            end
            default: begin
               if (!fetch_open || fetch_lpa != c.lpa) begin
                  push(mcbe_pkg::KIND_PROTOCOL, c.lpa, '0);
               end else begin
                  fetch_open = 0;
                  s = find_lpa(c.lpa);
                  if (s >= 0) push(mcbe_pkg::KIND_TRANSLATED, c.lpa, slot_ppa[s]);
                  else if (c.ppa == mcbe_pkg::ALL_ONES)
                     push(mcbe_pkg::KIND_NOT_MAPPED, c.lpa, mcbe_pkg::ALL_ONES);
                  else begin
                     add_entry(c.lpa, c.ppa, 0);
                     push(mcbe_pkg::KIND_TRANSLATED, c.lpa, c.ppa);
                  end
               end
            end
         endcase
         awaited[awaited.size()-1].last = 1'b1;
      endfunction

      function void check_word(mcbe_pkg::rsp_type got);
         mcbe_pkg::rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", got);
            return;
         end
         want = awaited.pop_front();
         if (got.kind != want.kind || got.lpa != want.lpa || got.ppa != want.ppa ||
             got.tpage_addr != want.tpage_addr || got.tpage_index != want.tpage_index ||
             got.byte_offset != want.byte_offset || got.last != want.last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %0d %h %h %h %h %h %b, got %0d %h %h %h %h %h %b",
                        want.kind, want.lpa, want.ppa, want.tpage_addr, want.tpage_index,
                        want.byte_offset, want.last, got.kind, got.lpa, got.ppa,
                        got.tpage_addr, got.tpage_index, got.byte_offset, got.last);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [55:0]  req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;

   mapping_cache_batch_evict uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   mapping_scoreboard board = new();
   bit calm = 0;
   bit rsp_taken = 1;
   int rsp_hold = 0;

   always #10 clock = ~clock;

   always @(posedge clock) begin
      mcbe_pkg::rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = mcbe_pkg::kind_type'(rsp_tuser);
         got.lpa = rsp_tdata[15:0];
         got.ppa = rsp_tdata[47:16];
         got.tpage_addr = rsp_tdata[79:48];
         got.tpage_index = rsp_tdata[86:80];
         got.byte_offset = rsp_tdata[97:87];
         got.last = rsp_tlast;
         board.check_word(got);
         rsp_taken = 1;
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_hold = calm ? 0 : $urandom_range(0, 13);
         rsp_taken = 0;
      end
      rsp_tready = (rsp_hold == 0);
      if (rsp_hold > 0) rsp_hold--;
   end

   task automatic send_word(mcbe_pkg::op_type op, logic [15:0] lpa, logic [31:0] ppa,
                            logic [6:0] slot);
      int gap;
      mcbe_pkg::cmd_type c;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      c.op = op;
      c.lpa = lpa;
      c.ppa = ppa;
      c.dir_slot = slot;
      req_tdata = {1'b0, slot, ppa, lpa};
      req_tuser = op;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_word(c);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_lpa();
      logic [6:0] page;
      case ($urandom_range(0, 4))
         0: page = 7'd0;
         1: page = 7'd1;
         2: page = 7'd2;
         3: page = 7'd127;
         default: return 16'($urandom);
      endcase
      return {page, 9'($urandom_range(0, 20))};
   endfunction

   function automatic logic [31:0] pick_ppa();
      return ($urandom_range(0, 9) == 0) ? mcbe_pkg::ALL_ONES : $urandom;
   endfunction

   initial begin
      logic [15:0] a;
      board.clear();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(mcbe_pkg::OP_TRANSLATE, 16'd5, '0, '0);
      send_word(mcbe_pkg::OP_FILL, 16'd5, 32'h1234, '0);
      send_word(mcbe_pkg::OP_SET_DIR, '0, 32'h0000_1000, 7'd0);
      send_word(mcbe_pkg::OP_SET_DIR, '0, 32'h0, 7'd127);
      send_word(mcbe_pkg::OP_TRANSLATE, 16'd5, '0, '0);
      send_word(mcbe_pkg::OP_FILL, 16'd6, 32'h1, '0);
      send_word(mcbe_pkg::OP_FILL, 16'd5, 32'hABCD, '0);
      send_word(mcbe_pkg::OP_TRANSLATE, 16'd5, '0, '0);
      send_word(mcbe_pkg::OP_TRANSLATE, 16'd7, '0, '0);
      send_word(mcbe_pkg::OP_TRANSLATE, 16'd8, '0, '0);
      send_word(mcbe_pkg::OP_FILL, 16'd8, mcbe_pkg::ALL_ONES, '0);
      send_word(mcbe_pkg::OP_TRANSLATE, 16'd9, '0, '0);
      send_word(mcbe_pkg::OP_MAP, 16'd9, 32'h55, '0);
      send_word(mcbe_pkg::OP_FILL, 16'd9, 32'h1, '0);
      send_word(mcbe_pkg::OP_MAP, 16'd9, 32'h55, '0);
      send_word(mcbe_pkg::OP_MAP, 16'hFFFF, mcbe_pkg::ALL_ONES, 7'h7F);
      send_word(mcbe_pkg::OP_MAP, 16'h0000, 32'h0, '0);
      send_word(mcbe_pkg::OP_SET_DIR, '0, mcbe_pkg::ALL_ONES, 7'd1);
      send_word(mcbe_pkg::OP_SET_DIR, '0, 32'h2000, 7'd2);
      send_word(mcbe_pkg::OP_SET_DIR, '0, 32'h3000, 7'd1);
      for (int i = 0; i < 34; i++)
         send_word(mcbe_pkg::OP_MAP, 16'd1024 + 16'(i), $urandom, '0);

      for (int n = 0; n < 55; n++) begin
         if (n % 40 == 20) calm = ~calm;
         case ($urandom_range(0, 9))
            0: send_word(mcbe_pkg::OP_SET_DIR, '0, pick_ppa(), 7'($urandom));
            1, 2, 3: send_word(mcbe_pkg::OP_MAP, pick_lpa(), pick_ppa(), 7'($urandom));
            4: send_word(mcbe_pkg::OP_FILL, pick_lpa(), pick_ppa(), 7'($urandom));
            default: begin
               a = pick_lpa();
               send_word(mcbe_pkg::OP_TRANSLATE, a, $urandom, 7'($urandom));
               if ($urandom_range(0, 3) != 0)
                  send_word(mcbe_pkg::OP_FILL, a, pick_ppa(), '0);
            end
         endcase
      end
      req_tvalid = 1'b0;
      calm = 0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0) $display("[mapping_cache_batch_evict] OK");
      else $display("[mapping_cache_batch_evict] ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("[mapping_cache_batch_evict] ERROR");
      $finish;
   end

endmodule

>>> sim.f
hdl/mcbe_pkg.sv
hdl/mcbe_cmd_fifo.sv
hdl/mcbe_engine.sv
hdl/mapping_cache_batch_evict.sv
verif/tb_mapping_cache_batch_evict.sv
